// ===== rtl/dns_a_record_extractor_assert.svh =====
// ----------------------------------------------------------------------------
// DNS A-record extractor assertion macros
// Shorthand for the clocked implications used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DNS_A_RECORD_EXTRACTOR_ASSERT_SVH
`define DNS_A_RECORD_EXTRACTOR_ASSERT_SVH

// same-cycle implication, clocked on clock, off during reset
`define DAE_CHK_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("dae check failed");

// next-cycle implication, clocked on clock, off during reset
`define DAE_CHK_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("dae check failed");

`endif

// ===== rtl/dae_pkg.sv =====
// ----------------------------------------------------------------------------
// DNS A-record extractor package
// Item types, parse phases and DNS field constants.
// ----------------------------------------------------------------------------
`default_nettype none

package dae_pkg;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [31:0] ipv4_address;
      logic        record_found;
      logic        run_end;
   } rsp_type;

   typedef enum logic [7:0] {
      PH_HEADER = 8'b0000_0001,
      PH_QLEN   = 8'b0000_0010,
      PH_QLABEL = 8'b0000_0100,
      PH_QTAIL  = 8'b0000_1000,
      PH_ANAME  = 8'b0001_0000,
      PH_AFIXED = 8'b0010_0000,
      PH_RDATA  = 8'b0100_0000,
      PH_DONE   = 8'b1000_0000
   } phase_type;

   localparam logic KIND_ADDRESS = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [15:0] TYPE_A       = 16'd1;
   localparam logic [15:0] A_LEN        = 16'd4;
   localparam logic [15:0] NAME_PTR_END = 16'd1;
   localparam logic [15:0] HDR_QD_HI    = 16'd4;
   localparam logic [15:0] HDR_QD_LO    = 16'd5;
   localparam logic [15:0] HDR_AN_HI    = 16'd6;
   localparam logic [15:0] HDR_AN_LO    = 16'd7;
   localparam logic [15:0] HDR_LAST     = 16'd11;
   localparam logic [15:0] QTAIL_LAST   = 16'd3;
   localparam logic [15:0] FIX_TYPE_HI  = 16'd0;
   localparam logic [15:0] FIX_TYPE_LO  = 16'd1;
   localparam logic [15:0] FIX_LEN_HI   = 16'd8;
   localparam logic [15:0] FIX_LEN_LO   = 16'd9;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

endpackage

`default_nettype wire

// ===== rtl/dns_a_record_extractor.sv =====
// ----------------------------------------------------------------------------
// DNS A-record extractor
// Parses a DNS response byte by byte and emits A-record addresses and an
// end-of-message summary.
// ----------------------------------------------------------------------------
//  channel  dir  payload                 handshake
//  req_     in   packet byte, final flag req_valid / req_ready
//  rsp_     out  kind, address, found    rsp_valid / rsp_ready
//
//  One byte is taken per cycle while req_ready is high; the parser state updates on acceptance.
//  A byte yields up to two items, queued in a four-entry result queue;
//  req_ready is high while at least two queue slots are free.
//  A final byte ending an A record gives two items, an address then a summary.
//  Reset and every final byte return the parser to the header phase.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_a_record_extractor (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire dae_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output dae_pkg::rsp_type      rsp_data
);
   import dae_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] offset_ff, offset_in;
   logic [15:0] quest_ff, quest_in;
   logic [15:0] answer_ff, answer_in;
   logic [7:0]  label_ff, label_in;
   logic [15:0] rtype_ff, rtype_in;
   logic [15:0] rlen_ff, rlen_in;
   logic [31:0] addr_ff, addr_in;
   logic        found_ff, found_in;

   rsp_type              slot_ff [QDEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff, count_in;

   logic        accept, pop, emit_addr, last;
   logic [7:0]  b;
   logic [31:0] addr_next;
   logic [1:0]  push_cnt;
   rsp_type     res0, res1, sum_rsp, addr_rsp;

   assign b         = req_data.packet_byte;
   assign last      = req_data.final_byte;
   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign addr_next = {addr_ff[23:0], b};

   always_comb begin
      phase_in  = phase_ff;
      offset_in = offset_ff;
      quest_in  = quest_ff;
      answer_in = answer_ff;
      label_in  = label_ff;
      rtype_in  = rtype_ff;
      rlen_in   = rlen_ff;
      addr_in   = addr_ff;
      found_in  = found_ff;
      emit_addr = 1'b0;
      unique case (phase_ff)
         PH_HEADER: begin
            if (offset_ff == HDR_QD_HI) quest_in = {b, quest_ff[7:0]};
            if (offset_ff == HDR_QD_LO) quest_in = {quest_ff[15:8], b};
            if (offset_ff == HDR_AN_HI) answer_in = {b, answer_ff[7:0]};
            if (offset_ff == HDR_AN_LO) answer_in = {answer_ff[15:8], b};
            if (offset_ff >= HDR_LAST) begin
               offset_in = '0;
               if (quest_in != '0) phase_in = PH_QLEN;
               else if (answer_in != '0) phase_in = PH_ANAME;
               else phase_in = PH_DONE;
            end else begin
               offset_in = offset_ff + 16'd1;
            end
         end
         PH_QLEN: begin
            if (b == 8'd0) begin
               phase_in  = PH_QTAIL;
               offset_in = '0;
            end else begin
               label_in = b;
               phase_in = PH_QLABEL;
            end
         end
         PH_QLABEL: begin
            label_in = label_ff - 8'd1;
            if (label_in == 8'd0) phase_in = PH_QLEN;
         end
         PH_QTAIL: begin
            if (offset_ff >= QTAIL_LAST) begin
               quest_in  = quest_ff - 16'd1;
               offset_in = '0;
               if (quest_in != '0) phase_in = PH_QLEN;
               else if (answer_ff != '0) phase_in = PH_ANAME;
               else phase_in = PH_DONE;
            end else begin
               offset_in = offset_ff + 16'd1;
            end
         end
         PH_ANAME: begin
            if (offset_ff >= NAME_PTR_END) begin
               phase_in  = PH_AFIXED;
               offset_in = '0;
            end else begin
               offset_in = offset_ff + 16'd1;
            end
         end
         PH_AFIXED: begin
            if (offset_ff == FIX_TYPE_HI) rtype_in = {b, rtype_ff[7:0]};
            if (offset_ff == FIX_TYPE_LO) rtype_in = {rtype_ff[15:8], b};
            if (offset_ff == FIX_LEN_HI) rlen_in = {b, rlen_ff[7:0]};
            if (offset_ff == FIX_LEN_LO) rlen_in = {rlen_ff[15:8], b};
            if (offset_ff >= FIX_LEN_LO) begin
               addr_in   = '0;
               offset_in = '0;
               if (rlen_in == '0) begin
                  answer_in = answer_ff - 16'd1;
                  phase_in  = (answer_in != '0) ? PH_ANAME : PH_DONE;
               end else begin
                  phase_in = PH_RDATA;
               end
            end else begin
               offset_in = offset_ff + 16'd1;
            end
         end
         PH_RDATA: begin
            addr_in = addr_next;
            if (({1'b0, offset_ff} + 17'd1) >= {1'b0, rlen_ff}) begin
               if (rtype_ff == TYPE_A && rlen_ff == A_LEN) begin
                  found_in  = 1'b1;
                  emit_addr = 1'b1;
               end
               answer_in = answer_ff - 16'd1;
               offset_in = '0;
               phase_in  = (answer_in != '0) ? PH_ANAME : PH_DONE;
            end else begin
               offset_in = offset_ff + 16'd1;
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      addr_rsp.result_kind  = KIND_ADDRESS;
      addr_rsp.ipv4_address = addr_next;
      addr_rsp.record_found = 1'b1;
      addr_rsp.run_end      = !last;
      sum_rsp.result_kind   = KIND_SUMMARY;
      sum_rsp.ipv4_address  = '0;
      sum_rsp.record_found  = found_in;
      sum_rsp.run_end       = 1'b1;
      res0 = emit_addr ? addr_rsp : sum_rsp;
      res1 = sum_rsp;

      if (last) begin
         phase_in  = PH_HEADER;
         offset_in = '0;
         quest_in  = '0;
         answer_in = '0;
         label_in  = '0;
         rtype_in  = '0;
         rlen_in   = '0;
         addr_in   = '0;
         found_in  = 1'b0;
      end
   end

   assign push_cnt  = accept ? ({1'b0, emit_addr} + {1'b0, last}) : 2'd0;
   assign wr_ptr_in = wr_ptr_ff + QPTR_W'(push_cnt);
   assign rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
   assign count_in  = count_ff + QCNT_W'(push_cnt) - QCNT_W'(pop);

   assign req_ready = (count_ff <= QCNT_W'(QDEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         offset_ff <= '0;
         quest_ff  <= '0;
         answer_ff <= '0;
         label_ff  <= '0;
         rtype_ff  <= '0;
         rlen_ff   <= '0;
         addr_ff   <= '0;
         found_ff  <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            offset_ff <= offset_in;
            quest_ff  <= quest_in;
            answer_ff <= answer_in;
            label_ff  <= label_in;
            rtype_ff  <= rtype_in;
            rlen_ff   <= rlen_in;
            addr_ff   <= addr_in;
            found_ff  <= found_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) slot_ff[wr_ptr_ff] <= res0;
      if (push_cnt == 2'd2) slot_ff[wr_ptr_ff + QPTR_W'(1)] <= res1;
   end

endmodule

`default_nettype wire

// ===== rtl/dae_checker.sv =====
// ----------------------------------------------------------------------------
// DNS A-record extractor port checker
// Watches the request and result channels for item ordering and content rules.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dns_a_record_extractor_assert.svh"

module dae_protocol_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire dae_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire dae_pkg::rsp_type rsp_data
);
   import dae_pkg::*;

   logic rsp_take, req_take, rsp_sum, rsp_addr, sum_clean;

   assign rsp_take  = rsp_valid && rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign rsp_sum   = rsp_valid && (rsp_data.result_kind == KIND_SUMMARY);
   assign rsp_addr  = rsp_valid && (rsp_data.result_kind == KIND_ADDRESS);
   assign sum_clean = (rsp_data.ipv4_address == '0) && rsp_data.run_end;

   `DAE_CHK_NOW(summary_shape, rsp_sum, sum_clean)
   `DAE_CHK_NOW(address_found, rsp_addr, rsp_data.record_found)
   `DAE_CHK_NEXT(address_then_summary, rsp_take && rsp_addr && !rsp_data.run_end, rsp_sum)
   `DAE_CHK_NEXT(rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `DAE_CHK_NEXT(summary_after_final, req_take && req_data.final_byte, rsp_valid)

endmodule

bind dns_a_record_extractor dae_protocol_checker u_dae_checker (.*);

`default_nettype wire

// ===== bench/dae_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DNS A-record extractor result checker
// Watches both channels of the extractor and parses every accepted byte in
// step with it. Each byte adds the addresses and end-of-message items it
// should produce to a queue. Every result item that comes out is checked
// field by field against the oldest of them. Hands back a failure count and
// a few totals.
// ----------------------------------------------------------------------------
module dae_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire dae_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire dae_pkg::rsp_type rsp_data,
   output int                    fail_count,
   output int                    pending,
   output int                    bytes_seen,
   output int                    addresses_seen,
   output int                    summaries_seen,
   output int                    double_bytes
);
   import dae_pkg::*;

   phase_type   stage;
   logic [15:0] pos;
   logic [15:0] qd_left;
   logic [15:0] an_left;
   logic [7:0]  label_left;
   logic [15:0] rr_type;
   logic [15:0] rr_len;
   logic [31:0] addr_acc;
   logic        a_seen;

   rsp_type due_results[$];

   task clear_parser();
      stage      = PH_HEADER;
      pos        = '0;
      qd_left    = '0;
      an_left    = '0;
      label_left = '0;
      rr_type    = '0;
      rr_len     = '0;
      addr_acc   = '0;
      a_seen     = 1'b0;
   endtask

   task open_answers();
      pos   = '0;
      stage = (an_left != 16'd0) ? PH_ANAME : PH_DONE;
   endtask

   task open_questions();
      pos = '0;
      if (qd_left != 16'd0)
         stage = PH_QLEN;
      else
         open_answers();
   endtask

   task close_answer();
      an_left = an_left - 16'd1;
      open_answers();
   endtask

   task automatic parse_byte(input req_type item);
      logic [7:0] b;
      rsp_type    outs[2];
      int         n;
      b = item.packet_byte;
      n = 0;
      case (stage)
         PH_HEADER: begin
            if (pos == HDR_QD_HI)
               qd_left[15:8] = b;
            else if (pos == HDR_QD_LO)
               qd_left[7:0] = b;
            else if (pos == HDR_AN_HI)
               an_left[15:8] = b;
            else if (pos == HDR_AN_LO)
               an_left[7:0] = b;
            if (pos >= HDR_LAST)
               open_questions();
            else
               pos = pos + 16'd1;
         end
         PH_QLEN: begin
            if (b == 8'd0) begin
               stage = PH_QTAIL;
               pos   = '0;
            end else begin
               label_left = b;
               stage      = PH_QLABEL;
            end
         end
         PH_QLABEL: begin
            label_left = label_left - 8'd1;
            if (label_left == 8'd0)
               stage = PH_QLEN;
         end
         PH_QTAIL: begin
            if (pos >= QTAIL_LAST) begin
               qd_left = qd_left - 16'd1;
               open_questions();
            end else begin
               pos = pos + 16'd1;
            end
         end
         PH_ANAME: begin
            if (pos >= NAME_PTR_END) begin
               stage = PH_AFIXED;
               pos   = '0;
            end else begin
               pos = pos + 16'd1;
            end
         end
         PH_AFIXED: begin
            if (pos == FIX_TYPE_HI)
               rr_type[15:8] = b;
            else if (pos == FIX_TYPE_LO)
               rr_type[7:0] = b;
            else if (pos == FIX_LEN_HI)
               rr_len[15:8] = b;
            else if (pos == FIX_LEN_LO)
               rr_len[7:0] = b;
            if (pos >= FIX_LEN_LO) begin
               addr_acc = '0;
               pos      = '0;
               if (rr_len == 16'd0)
                  close_answer();
               else
                  stage = PH_RDATA;
            end else begin
               pos = pos + 16'd1;
            end
         end
         PH_RDATA: begin
            addr_acc = {addr_acc[23:0], b};
            if ({16'd0, pos} + 32'd1 >= {16'd0, rr_len}) begin
               if (rr_type == TYPE_A && rr_len == A_LEN) begin
                  a_seen = 1'b1;
                  outs[n] = '{KIND_ADDRESS, addr_acc, 1'b1, 1'b0};
                  n++;
               end
               close_answer();
            end else begin
               pos = pos + 16'd1;
            end
         end
         default: ;
      endcase
      if (item.final_byte) begin
         outs[n] = '{KIND_SUMMARY, 32'd0, a_seen, 1'b0};
         n++;
         clear_parser();
      end
      if (n > 0)
         outs[n - 1].run_end = 1'b1;
      if (n > 1)
         double_bytes++;
      for (int i = 0; i < n; i++)
         due_results.push_back(outs[i]);
   endtask

   initial clear_parser();

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         clear_parser();
         due_results.delete();
      end else begin
         if (req_valid && req_ready) begin
            parse_byte(req_data);
            bytes_seen++;
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (got.result_kind == KIND_SUMMARY)
               summaries_seen++;
            else
               addresses_seen++;
            if (due_results.size() == 0) begin
               $error("result item with nothing due: kind %0d address %h",
                      got.result_kind, got.ipv4_address);
               fail_count++;
            end else begin
               want = due_results.pop_front();
               if (got.result_kind !== want.result_kind) begin
                  $error("result_kind expected %0d actual %0d",
                         want.result_kind, got.result_kind);
                  fail_count++;
               end
               if (got.ipv4_address !== want.ipv4_address) begin
                  $error("ipv4_address expected %h actual %h",
                         want.ipv4_address, got.ipv4_address);
                  fail_count++;
               end
               if (got.record_found !== want.record_found) begin
                  $error("record_found expected %0d actual %0d",
                         want.record_found, got.record_found);
                  fail_count++;
               end
               if (got.run_end !== want.run_end) begin
                  $error("run_end expected %0d actual %0d", want.run_end, got.run_end);
                  fail_count++;
               end
            end
         end
      end
      pending = due_results.size();
   end

endmodule

// ===== bench/tb_dns_a_record_extractor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DNS A-record extractor testbench
// Feeds the extractor whole DNS responses a byte at a time. It starts with a
// truncated one-byte message and an A record that ends on the final byte.
// Random messages follow, most of them well formed, with questions, answers
// of mixed types and lengths, trailing bytes and cuts at random points. The
// rest is noise. Both sides idle at random. The receiver once holds off
// while the sender keeps pushing. The checker alongside gives the verdict.
// ----------------------------------------------------------------------------
module tb_dns_a_record_extractor;
   import dae_pkg::*;

   localparam int BYTE_TARGET   = 500;
   localparam int HOLD_CYCLES   = 150;
   localparam int QUIET_LIMIT   = 1000;
   localparam int DRAIN_CYCLES  = 20;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int pending;
   int bytes_seen;
   int addresses_seen;
   int summaries_seen;
   int double_bytes;

   logic [7:0] msg[$];
   int         sent         = 0;
   int         messages     = 0;
   int         quiet_cycles = 0;
   logic       calm_tx      = 1'b0;
   logic       calm_rx      = 1'b0;
   logic       rush         = 1'b0;
   logic       hold_request = 1'b0;
   logic       hold_done    = 1'b0;

   always #2 clock = ~clock;

   dns_a_record_extractor uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   dae_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .fail_count     (fail_count),
      .pending        (pending),
      .bytes_seen     (bytes_seen),
      .addresses_seen (addresses_seen),
      .summaries_seen (summaries_seen),
      .double_bytes   (double_bytes)
   );

   function automatic logic [7:0] rnd_byte();
      rnd_byte = 8'($urandom_range(0, 255));
   endfunction

   task automatic put_byte(input logic [7:0] b, input logic last);
      int gap;
      if (sent % 32 == 0)
         calm_tx = ($urandom_range(0, 3) == 0);
      gap = (rush || calm_tx) ? 0 : $urandom_range(0, 8);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{b, last};
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic send_message();
      for (int i = 0; i < msg.size(); i++)
         put_byte(msg[i], i == msg.size() - 1);
      messages++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending == 0);
   endtask

   task automatic compose_message();
      int          qd;
      int          an;
      int          n_lab;
      int          len;
      int          cut;
      logic [15:0] rtype;
      logic [15:0] rlen;
      msg.delete();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 20)) msg.push_back(rnd_byte());
         return;
      end
      qd = $urandom_range(0, 3);
      an = $urandom_range(0, 4);
      if ($urandom_range(0, 15) == 0)
         qd = $urandom_range(0, 65535);
      if ($urandom_range(0, 15) == 0)
         an = $urandom_range(0, 65535);
      repeat (12) msg.push_back(rnd_byte());
      msg[4] = qd[15:8];
      msg[5] = qd[7:0];
      msg[6] = an[15:8];
      msg[7] = an[7:0];
      for (int i = 0; i < qd && i < 4; i++) begin
         n_lab = $urandom_range(0, 3);
         for (int j = 0; j < n_lab; j++) begin
            len = ($urandom_range(0, 39) == 0) ? $urandom_range(192, 255)
                                                : $urandom_range(1, 6);
            msg.push_back(len[7:0]);
            repeat (len) msg.push_back(rnd_byte());
         end
         msg.push_back(8'h00);
         repeat (4) msg.push_back(rnd_byte());
      end
      for (int i = 0; i < an && i < 5; i++) begin
         msg.push_back(8'hC0);
         msg.push_back(rnd_byte());
         case ($urandom_range(0, 7))
            0: rtype = {rnd_byte(), rnd_byte()};
            1: rtype = 16'h0100;
            2: rtype = 16'd5;
            default: rtype = TYPE_A;
         endcase
         if (rtype == TYPE_A && $urandom_range(0, 4) != 0)
            rlen = A_LEN;
         else if ($urandom_range(0, 9) == 0)
            rlen = {rnd_byte(), rnd_byte()};
         else
            rlen = 16'($urandom_range(0, 6));
         msg.push_back(rtype[15:8]);
         msg.push_back(rtype[7:0]);
         repeat (6) msg.push_back(rnd_byte());
         msg.push_back(rlen[15:8]);
         msg.push_back(rlen[7:0]);
         repeat ((rlen > 16) ? 16 : rlen) msg.push_back(rnd_byte());
      end
      repeat ($urandom_range(0, 3)) msg.push_back(rnd_byte());
      if ($urandom_range(0, 4) == 0) begin
         cut = $urandom_range(1, msg.size());
         while (msg.size() > cut)
            void'(msg.pop_back());
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // receiver: random stalls, one long hold on request
   initial begin
      int gap;
      int served;
      served = 0;
      wait (!reset);
      forever begin
         if (served % 32 == 0)
            calm_rx = ($urandom_range(0, 3) == 0);
         if (hold_request && !hold_done) begin
            gap       = HOLD_CYCLES;
            hold_done = 1'b1;
         end else begin
            gap = calm_rx ? 0 : $urandom_range(0, 8);
         end
         @(negedge clock);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         served++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      wait (!reset);

      // truncated single-byte message
      msg = '{8'hFF};
      send_message();

      // no questions, one A record whose last address byte is final
      msg = '{8'h00, 8'h00, 8'h81, 8'h80, 8'h00, 8'h00, 8'h00, 8'h01,
              8'h00, 8'h00, 8'h00, 8'h00,
              8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01,
              8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h04,
              8'hFF, 8'h00, 8'hA5, 8'h5A};
      send_message();
      wait_drained();

      while (sent < BYTE_TARGET) begin
         if (!hold_request && sent >= 200) begin
            hold_request = 1'b1;
            rush         = 1'b1;
            repeat (12) begin
               msg = '{rnd_byte()};
               send_message();
            end
            rush = 1'b0;
            wait_drained();
         end
         compose_message();
         send_message();
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d bytes in %0d messages: %0d addresses, %0d end-of-message items",
               bytes_seen, messages, addresses_seen, summaries_seen);
      $display("%0d bytes gave an address and a summary together", double_bytes);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
